FILE: src/cpf_pkg.sv
// shared types and constants of the cpf check digit validator
// no dependencies; imported by every module of the block
`default_nettype none

package cpf_pkg;

  localparam int unsigned IdWidth      = 37;
  localparam int unsigned CheckWidth   = 7;
  localparam int unsigned DigitWidth   = 4;
  localparam int unsigned DigitCount   = 9;
  localparam int unsigned Radix        = 10;
  localparam int unsigned CheckModulus = 11;
  localparam int unsigned PairModulus  = 100;

  localparam logic [IdWidth-1:0] TenDigitFloor    = 37'd1000000000;
  localparam logic [IdWidth-1:0] TwelveDigitFloor = 37'd100000000000;

  typedef enum logic [1:0] {
    STATUS_VALID    = 2'd0,
    STATUS_MISMATCH = 2'd1,
    STATUS_SHORT    = 2'd2,
    STATUS_LONG     = 2'd3
  } cpf_status_e;

  typedef struct packed {
    logic [IdWidth-1:0] id_number;
  } cpf_in_t;

  typedef struct packed {
    cpf_status_e           status;
    logic [CheckWidth-1:0] expected_check;
  } cpf_out_t;

  // split number: range class, d1..d9 (index 0 is d1) and the trailing pair d10 d11
  typedef struct packed {
    cpf_status_e                             cls;
    logic [DigitCount-1:0][DigitWidth-1:0]   dig;
    logic [CheckWidth-1:0]                   pair;
  } cpf_digits_t;

endpackage

`default_nettype wire

FILE: src/cpf_stream_if.sv
// valid/ready stream channel with a typed payload
// no dependencies; the payload type is set where the channel is instantiated
`default_nettype none

interface cpf_stream_if #(
  parameter type T_t = logic
);
  logic valid;
  logic ready;
  T_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: src/cpf_pipe_ctrl.sv
// valid bits and load enables of a bubble-collapsing register pipeline
// uses cpf_pkg; instantiated by the split and check stages
`default_nettype none

module cpf_pipe_ctrl
  import cpf_pkg::*;
#(
  parameter int unsigned NumStages = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [NumStages-1:0] load_o
);

  logic [NumStages-1:0] valid_q, valid_d, load;

  always_comb begin
    // a stage may load when it is empty or its content moves on
    load[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int s = NumStages - 2; s >= 0; s--) begin
      load[s] = !valid_q[s] || load[s+1];
    end
    valid_d = valid_q;
    if (load[0]) valid_d[0] = in_valid_i;
    for (int s = 1; s < NumStages; s++) begin
      if (load[s]) valid_d[s] = valid_q[s-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign load_o      = load;
  assign in_ready_o  = load[0];
  assign out_valid_o = valid_q[NumStages-1];

  a_ready_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (valid_q[NumStages-1] && !out_ready_i))
    else $error("input stalled although the pipeline can move");

  a_item_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |-> ($countones(valid_q) == $past($countones(valid_q))
      + int'($past(in_valid_i && in_ready_o)) - int'($past(out_valid_o && out_ready_i))))
    else $error("item lost or duplicated in pipeline");

endmodule

`default_nettype wire

FILE: src/cpf_split.sv
// decimal split: range class, digits d1..d9 and the trailing pair of the number
// uses cpf_pkg and cpf_pipe_ctrl; six register stages
`default_nettype none

module cpf_split
  import cpf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [IdWidth-1:0] id_number_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cpf_digits_t        digits_o
);

  localparam int unsigned NumStages = 6;

  // reciprocals ceil(2^k / d), exact for the numerator width in use
  localparam longint unsigned TenE7     = 64'd10000000;
  localparam longint unsigned RecipE7   = ((64'd1 << 47) + 64'd78125 - 64'd1) / 64'd78125;
  localparam longint unsigned RecipR100 = ((64'd1 << 27) + 64'd25 - 64'd1) / 64'd25;
  localparam longint unsigned RecipM1   = ((64'd1 << 21) + 64'd10 - 64'd1) / 64'd10;
  localparam longint unsigned RecipM2   = ((64'd1 << 24) + 64'd100 - 64'd1) / 64'd100;
  localparam longint unsigned RecipM3   = ((64'd1 << 27) + 64'd1000 - 64'd1) / 64'd1000;
  localparam longint unsigned RecipM4   = ((64'd1 << 31) + 64'd10000 - 64'd1) / 64'd10000;
  localparam longint unsigned RecipH1   = ((64'd1 << 18) + 64'd10 - 64'd1) / 64'd10;
  localparam longint unsigned RecipH2   = ((64'd1 << 21) + 64'd100 - 64'd1) / 64'd100;
  localparam longint unsigned RecipH3   = ((64'd1 << 24) + 64'd1000 - 64'd1) / 64'd1000;

  function automatic logic [DigitWidth-1:0] low_digit(input logic [16:0] num,
                                                      input logic [16:0] quo);
    logic [20:0] ten_quo;
    ten_quo = 21'(quo) * 21'(Radix);
    return num[3:0] - ten_quo[3:0];
  endfunction

  logic [NumStages-1:0] load;

  cpf_pipe_ctrl #(
    .NumStages(NumStages)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .load_o     (load)
  );

  // stage registers
  logic [IdWidth-1:0] id_a_q;
  cpf_status_e        cls_b_q, cls_c_q, cls_d_q, cls_e_q;
  logic [13:0]        hi_b_q, hi_c_q;
  logic [23:0]        idlo_b_q, rem_c_q;
  logic [9:0]         hq1_c_q;
  logic [6:0]         hq2_c_q;
  logic [3:0]         hq3_c_q;
  logic [16:0]        mid_d_q, mid_e_q;
  logic [6:0]         pair_lo_d_q, pair_e_q;
  logic [3:0][3:0]    dh_d_q, dh_e_q;
  logic [13:0]        mq1_e_q;
  logic [9:0]         mq2_e_q;
  logic [6:0]         mq3_e_q;
  logic [3:0]         mq4_e_q;
  cpf_digits_t        digits_q;

  // stage b: range class and top four digits as one quotient
  cpf_status_e cls_b_d;
  logic [60:0] hi_prod;
  always_comb begin
    if (id_a_q < TenDigitFloor) begin
      cls_b_d = STATUS_SHORT;
    end else if (id_a_q >= TwelveDigitFloor) begin
      cls_b_d = STATUS_LONG;
    end else begin
      cls_b_d = STATUS_VALID;
    end
    // id / 10^7 = (id >> 7) / 5^7
    hi_prod = 61'(id_a_q[36:7]) * 61'(RecipE7);
  end

  // stage c: low seven digits as remainder, quotients of the top part
  logic [37:0] hi_scaled;
  logic [31:0] hp1, hp2, hp3;
  always_comb begin
    hi_scaled = 38'(hi_b_q) * 38'(TenE7);
    hp1 = 32'(hi_b_q) * 32'(RecipH1);
    hp2 = 32'(hi_b_q) * 32'(RecipH2);
    hp3 = 32'(hi_b_q) * 32'(RecipH3);
  end

  // stage d: middle five digits as quotient by a hundred, top digits
  logic [44:0]     mid_prod;
  logic [3:0][3:0] dh_d;
  always_comb begin
    mid_prod = 45'(rem_c_q[23:2]) * 45'(RecipR100);
    dh_d[0]  = hq3_c_q;
    dh_d[1]  = low_digit(17'(hq2_c_q), 17'(hq3_c_q));
    dh_d[2]  = low_digit(17'(hq1_c_q), 17'(hq2_c_q));
    dh_d[3]  = low_digit(17'(hi_c_q), 17'(hq1_c_q));
  end

  // stage e: trailing pair, quotients of the middle part
  logic [23:0] hund_mid;
  logic [34:0] mp1, mp2, mp3, mp4;
  always_comb begin
    hund_mid = 24'(mid_d_q) * 24'(PairModulus);
    mp1 = 35'(mid_d_q) * 35'(RecipM1);
    mp2 = 35'(mid_d_q) * 35'(RecipM2);
    mp3 = 35'(mid_d_q) * 35'(RecipM3);
    mp4 = 35'(mid_d_q) * 35'(RecipM4);
  end

  // stage f: all nine digits
  cpf_digits_t digits_d;
  always_comb begin
    digits_d.cls    = cls_e_q;
    digits_d.pair   = pair_e_q;
    digits_d.dig[0] = dh_e_q[0];
    digits_d.dig[1] = dh_e_q[1];
    digits_d.dig[2] = dh_e_q[2];
    digits_d.dig[3] = dh_e_q[3];
    digits_d.dig[4] = mq4_e_q;
    digits_d.dig[5] = low_digit(17'(mq3_e_q), 17'(mq4_e_q));
    digits_d.dig[6] = low_digit(17'(mq2_e_q), 17'(mq3_e_q));
    digits_d.dig[7] = low_digit(17'(mq1_e_q), 17'(mq2_e_q));
    digits_d.dig[8] = low_digit(mid_e_q, 17'(mq1_e_q));
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      id_a_q <= id_number_i;
    end
    if (load[1]) begin
      cls_b_q  <= cls_b_d;
      hi_b_q   <= hi_prod[60:47];
      idlo_b_q <= id_a_q[23:0];
    end
    if (load[2]) begin
      cls_c_q <= cls_b_q;
      hi_c_q  <= hi_b_q;
      rem_c_q <= idlo_b_q - hi_scaled[23:0];
      hq1_c_q <= hp1[27:18];
      hq2_c_q <= hp2[27:21];
      hq3_c_q <= hp3[27:24];
    end
    if (load[3]) begin
      cls_d_q     <= cls_c_q;
      mid_d_q     <= mid_prod[43:27];
      pair_lo_d_q <= rem_c_q[6:0];
      dh_d_q      <= dh_d;
    end
    if (load[4]) begin
      cls_e_q  <= cls_d_q;
      mid_e_q  <= mid_d_q;
      pair_e_q <= pair_lo_d_q - hund_mid[6:0];
      dh_e_q   <= dh_d_q;
      mq1_e_q  <= mp1[34:21];
      mq2_e_q  <= mp2[33:24];
      mq3_e_q  <= mp3[33:27];
      mq4_e_q  <= mp4[34:31];
    end
    if (load[5]) begin
      digits_q <= digits_d;
    end
  end

  assign digits_o = digits_q;

  logic digits_ok;
  always_comb begin
    digits_ok = 1'b1;
    for (int i = 0; i < DigitCount; i++) begin
      if (digits_q.dig[i] > 4'(Radix - 1)) digits_ok = 1'b0;
    end
  end

  a_decimal_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && digits_q.cls == STATUS_VALID) |-> (digits_ok && digits_q.pair < 7'd100))
    else $error("split produced a non-decimal digit");

endmodule

`default_nettype wire

FILE: src/cpf_check.sv
// weighted mod-11 check pair from d1..d9 and comparison with the trailing pair
// uses cpf_pkg and cpf_pipe_ctrl; three register stages, the last is the result register
`default_nettype none

module cpf_check
  import cpf_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  cpf_digits_t digits_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output cpf_out_t    result_o
);

  localparam int unsigned NumStages = 3;
  localparam longint unsigned RecipMod11 =
    ((64'd1 << 14) + 64'(CheckModulus) - 64'd1) / 64'(CheckModulus);

  // exact for sums below 1024
  function automatic logic [3:0] mod11(input logic [9:0] sum);
    logic [20:0] prod;
    logic [10:0] eleven_q;
    prod     = 21'(sum) * 21'(RecipMod11);
    eleven_q = 11'(prod[20:14]) * 11'(CheckModulus);
    return sum[3:0] - eleven_q[3:0];
  endfunction

  function automatic logic [3:0] check_digit(input logic [3:0] rem);
    return (rem < 4'd2) ? 4'd0 : 4'(4'(CheckModulus) - rem);
  endfunction

  logic [NumStages-1:0] load;

  cpf_pipe_ctrl #(
    .NumStages(NumStages)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .load_o     (load)
  );

  cpf_status_e           cls_s_q, cls_c_q;
  logic [CheckWidth-1:0] pair_s_q, pair_c_q;
  logic [8:0]            s1_q;
  logic [9:0]            s2b_q, s2_q;
  logic [3:0]            c1_q;
  cpf_out_t              result_q;

  // weights 10..2 for the first sum, 11..3 for the second
  logic [8:0] s1_d;
  logic [9:0] s2b_d;
  always_comb begin
    s1_d  = '0;
    s2b_d = '0;
    for (int i = 0; i < DigitCount; i++) begin
      s1_d  = s1_d + 9'(digits_i.dig[i]) * 9'(10 - i);
      s2b_d = s2b_d + 10'(digits_i.dig[i]) * 10'(11 - i);
    end
  end

  logic [3:0] c1_d;
  always_comb begin
    c1_d = check_digit(mod11(10'(s1_q)));
  end

  logic [3:0]            c2;
  logic [CheckWidth-1:0] pair_calc;
  cpf_out_t              result_d;
  always_comb begin
    c2        = check_digit(mod11(s2_q));
    pair_calc = 7'(c1_q) * 7'(Radix) + 7'(c2);
    if (cls_c_q != STATUS_VALID) begin
      result_d.status         = cls_c_q;
      result_d.expected_check = '0;
    end else begin
      result_d.status         = (pair_calc == pair_c_q) ? STATUS_VALID : STATUS_MISMATCH;
      result_d.expected_check = pair_calc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      cls_s_q  <= digits_i.cls;
      pair_s_q <= digits_i.pair;
      s1_q     <= s1_d;
      s2b_q    <= s2b_d;
    end
    if (load[1]) begin
      cls_c_q  <= cls_s_q;
      pair_c_q <= pair_s_q;
      c1_q     <= c1_d;
      s2_q     <= s2b_q + {5'd0, c1_d, 1'b0};
    end
    if (load[2]) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

`default_nettype wire

FILE: src/cpf_check_digit_validator.sv
// Identity number check-digit validator, top level.
// Uses cpf_pkg, cpf_stream_if, cpf_split and cpf_check.
//
// id_i carries one 37-bit binary identity number per item; res_o returns one
// result per item in the same order: a status (valid, mismatch, under ten
// digits, over eleven digits) and the computed check pair as first digit
// times ten plus second (zero when the number is out of range).
// Both channels use valid/ready; an item moves when both are high.
//
// Throughput is one item per cycle while res_o is not stalled. There are nine
// register stages from id_i to res_o, the first loaded at the accepting edge.
// Six of them split the number into decimal digits with
// constant reciprocal multiplies, three more form the weighted sums, reduce
// them mod 11 and compare.
// When res_o is stalled the result register holds its item, the stages behind
// it keep filling and id_i.ready drops only once all nine stages are full.
// Reset clears the stage valid bits; no other state is kept.
`default_nettype none

module cpf_check_digit_validator
  import cpf_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  cpf_stream_if.sink    id_i,
  cpf_stream_if.source  res_o
);

  logic        dig_valid, dig_ready;
  cpf_digits_t digits;
  cpf_out_t    result;

  cpf_split u_split (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (id_i.valid),
    .in_ready_o (id_i.ready),
    .id_number_i(id_i.data.id_number),
    .out_valid_o(dig_valid),
    .out_ready_i(dig_ready),
    .digits_o   (digits)
  );

  cpf_check u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (dig_valid),
    .in_ready_o (dig_ready),
    .digits_i   (digits),
    .out_valid_o(res_o.valid),
    .out_ready_i(res_o.ready),
    .result_o   (result)
  );

  assign res_o.data = result;

  a_range_no_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (result.status == STATUS_SHORT || result.status == STATUS_LONG))
      |-> (result.expected_check == '0))
    else $error("out of range item carries a check pair");

  a_pair_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> (result.expected_check <= 7'd99))
    else $error("check pair above two decimal digits");

endmodule

`default_nettype wire
